// ===== hw/rtl/rgbpa_pkg.sv =====
`default_nettype none

package rgbpa_pkg;

	// Largest channel value, used for saturation and for divide by zero.
	localparam logic [7:0] ChanMax = 8'hFF;

	// Operation codes held in the operation register.
	// Codes eleven to fifteen have no member and pass the base channel through.
	typedef enum logic [3:0] {
		OP_AND     = 4'd0,
		OP_OR      = 4'd1,
		OP_XOR     = 4'd2,
		OP_ADD     = 4'd3,
		OP_SUB     = 4'd4,
		OP_MUL     = 4'd5,
		OP_DIV     = 4'd6,
		OP_MOD     = 4'd7,
		OP_ABSDIFF = 4'd8,
		OP_MAX     = 4'd9,
		OP_MIN     = 4'd10
	} op_t;

	typedef struct packed {
		logic [7:0] base_red;
		logic [7:0] base_green;
		logic [7:0] base_blue;
		logic       base_valid;
		logic [7:0] mask_red;
		logic [7:0] mask_green;
		logic [7:0] mask_blue;
		logic       mask_valid;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} pix_out_t;

	// Control that travels with one channel through the lane.
	typedef struct packed {
		op_t  op;
		logic pass;
	} lane_ctl_t;

	// Partial state of the restoring divider.
	typedef struct packed {
		logic [7:0] rem;
		logic [7:0] quo;
	} div_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rgbpa_lane.sv =====
`default_nettype none

module rgbpa_lane (
	input  wire logic                 clk,
	input  wire rgbpa_pkg::lane_ctl_t ctl,
	input  wire logic [7:0]           a,
	input  wire logic [7:0]           b,
	output logic [7:0]                y
);

	// One step of restoring division: brings in one dividend bit.
	function automatic rgbpa_pkg::div_t div_step(input rgbpa_pkg::div_t st,
			input logic abit, input logic [7:0] d);
		logic [8:0]      t;
		logic            ge;
		rgbpa_pkg::div_t nx;
		t       = {st.rem, abit};
		ge      = (t >= {1'b0, d});
		nx.rem  = ge ? 8'(t - {1'b0, d}) : t[7:0];
		nx.quo  = {st.quo[6:0], ge};
		return nx;
	endfunction

	rgbpa_pkg::lane_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [7:0]           a_s1, a_s2, a_s3, a_s4, a_s5;
	logic [7:0]           b_s1, b_s2, b_s3, b_s4, b_s5;
	logic [7:0]           alu_s2, alu_s3, alu_s4, alu_s5;
	logic [15:0]          prod_s2;
	rgbpa_pkg::div_t      dv_s2, dv_s3, dv_s4, dv_s5;
	logic [7:0]           y_s6;

	logic [8:0]           sum;
	logic [7:0]           alu_c;
	logic [7:0]           mul_sat;
	logic [7:0]           fin_c;
	rgbpa_pkg::div_t      dv_zero;

	assign dv_zero = '0;
	assign sum     = {1'b0, a_s1} + {1'b0, b_s1};
	assign mul_sat = (|prod_s2[15:8]) ? rgbpa_pkg::ChanMax : prod_s2[7:0];

	// Operations resolved in the first lane stage; the others are filled in further down.
	always_comb begin
		case (ctl_s1.op)
			rgbpa_pkg::OP_AND:     alu_c = a_s1 & b_s1;
			rgbpa_pkg::OP_OR:      alu_c = a_s1 | b_s1;
			rgbpa_pkg::OP_XOR:     alu_c = a_s1 ^ b_s1;
			rgbpa_pkg::OP_ADD:     alu_c = sum[8] ? rgbpa_pkg::ChanMax : sum[7:0];
			rgbpa_pkg::OP_SUB:     alu_c = (a_s1 > b_s1) ? 8'(a_s1 - b_s1) : 8'd0;
			rgbpa_pkg::OP_ABSDIFF: alu_c = (a_s1 > b_s1) ? 8'(a_s1 - b_s1)
					: 8'(b_s1 - a_s1);
			rgbpa_pkg::OP_MAX:     alu_c = (a_s1 > b_s1) ? a_s1 : b_s1;
			rgbpa_pkg::OP_MIN:     alu_c = (a_s1 < b_s1) ? a_s1 : b_s1;
			default:               alu_c = a_s1;
		endcase
	end

	always_comb begin
		case (ctl_s5.op)
			rgbpa_pkg::OP_DIV: fin_c = (b_s5 == 8'd0) ? rgbpa_pkg::ChanMax : dv_s5.quo;
			rgbpa_pkg::OP_MOD: fin_c = (b_s5 == 8'd0) ? a_s5 : dv_s5.rem;
			default:           fin_c = alu_s5;
		endcase
		if (ctl_s5.pass) begin
			fin_c = a_s5;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= a;
		b_s1    <= b;
		ctl_s1  <= ctl;

		a_s2    <= a_s1;
		b_s2    <= b_s1;
		ctl_s2  <= ctl_s1;
		alu_s2  <= alu_c;
		prod_s2 <= a_s1 * b_s1;
		dv_s2   <= div_step(div_step(dv_zero, a_s1[7], b_s1), a_s1[6], b_s1);

		a_s3    <= a_s2;
		b_s3    <= b_s2;
		ctl_s3  <= ctl_s2;
		alu_s3  <= (ctl_s2.op == rgbpa_pkg::OP_MUL) ? mul_sat : alu_s2;
		dv_s3   <= div_step(div_step(dv_s2, a_s2[5], b_s2), a_s2[4], b_s2);

		a_s4    <= a_s3;
		b_s4    <= b_s3;
		ctl_s4  <= ctl_s3;
		alu_s4  <= alu_s3;
		dv_s4   <= div_step(div_step(dv_s3, a_s3[3], b_s3), a_s3[2], b_s3);

		a_s5    <= a_s4;
		b_s5    <= b_s4;
		ctl_s5  <= ctl_s4;
		alu_s5  <= alu_s4;
		dv_s5   <= div_step(div_step(dv_s4, a_s4[1], b_s4), a_s4[0], b_s4);

		y_s6    <= fin_c;
	end

	assign y = y_s6;

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_pixel_arithmetic_unit_top.sv =====
`default_nettype none

// Per-channel arithmetic on RGB pixel pairs.
//
// Input channel: a pixel pair on pixel_in is transferred at every rising edge
// at which start is high and busy is low. The unit never pushes back, so busy
// stays low and a new pair may be transferred in every cycle.
// Result channel: done is high for exactly one cycle while result holds the
// pixel; the transfer completes at the edge that ends that cycle. The
// receiver cannot hold results off, and none is needed, since results leave
// in the order in which pairs arrived, one per cycle at most.
// Throughput is one pixel pair per cycle. From the input transfer to the result
// transfer, a pair passes the input register, the restoring divider, which
// resolves two quotient bits in each of four stages, and the output register
// that selects the final value.
// Configuration: cfg_wdata is written into the operation register at any edge
// with cfg_wen high; it should only change while no pair is in flight.
// Reset clears the operation register to AND and empties the pipeline, so no
// spurious done appears afterwards.
module rgb_pixel_arithmetic_unit_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire rgbpa_pkg::pix_in_t pixel_in,
	output logic                    done,
	output rgbpa_pkg::pix_out_t     result,
	input  wire logic               cfg_wen,
	input  wire logic [3:0]         cfg_wdata
);

	rgbpa_pkg::op_t       op_q;
	rgbpa_pkg::lane_ctl_t ctl;
	logic                 accept;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	// The pipeline always advances, so a transfer is never refused.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Operation register; unused codes are kept as written and fall through
	// to the pass-through arm of the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= rgbpa_pkg::OP_AND;
		end else if (cfg_wen) begin
			op_q <= rgbpa_pkg::op_t'(cfg_wdata);
		end
	end

	// An invalid base or mask pixel forwards the base pixel unchanged.
	assign ctl.op   = op_q;
	assign ctl.pass = !(pixel_in.base_valid && pixel_in.mask_valid);

	// Valid bits run alongside the lane data; the data registers need no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	rgbpa_lane u_lane_red (
		.clk (clk),
		.ctl (ctl),
		.a   (pixel_in.base_red),
		.b   (pixel_in.mask_red),
		.y   (result.out_red)
	);

	rgbpa_lane u_lane_green (
		.clk (clk),
		.ctl (ctl),
		.a   (pixel_in.base_green),
		.b   (pixel_in.mask_green),
		.y   (result.out_green)
	);

	rgbpa_lane u_lane_blue (
		.clk (clk),
		.ctl (ctl),
		.a   (pixel_in.base_blue),
		.b   (pixel_in.mask_blue),
		.y   (result.out_blue)
	);

	assign done = vld_s6;

	// Every transfer in produces a result at the end of the pipeline.
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##6 done)
		else $error("accepted pixel pair produced no result");

	// No result appears without a matching earlier transfer.
	a_out_from_in: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 6))
		else $error("result without a matching input transfer");

	// An invalid base pixel is forwarded untouched; the red and blue channels are checked.
	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !pixel_in.base_valid) |-> ##6
		(result.out_red == $past(pixel_in.base_red, 6) &&
		 result.out_blue == $past(pixel_in.base_blue, 6)))
		else $error("invalid pixel was not passed through");

endmodule

`default_nettype wire
